FILE: design/spq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
// Beat structs for both channels, request and status codes, cell command bundle.
// No dependencies.
package spq_pkg;

  localparam int VAL_W     = 32;
  localparam int OCC_W     = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic REQ_STORE    = 1'b0;
  localparam logic REQ_RETRIEVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } out_beat_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic                    store;
    logic                    retrieve;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: design/spq_cell.sv
// One storage cell of the sorted row: holds one entry, compares it to the
// broadcast value and shifts with its neighbors. Depends on spq_pkg.
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_cmd_t               cmd,
  input  logic                             occupied,
  input  logic                             at_tail,
  input  logic                             left_take,
  input  logic signed [spq_pkg::VAL_W-1:0] left_entry,
  input  logic signed [spq_pkg::VAL_W-1:0] right_entry,
  output logic                             take,
  output logic signed [spq_pkg::VAL_W-1:0] entry
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    greater;

  assign greater = occupied && (entry_r > cmd.value);
  // take a new entry when this cell is past the insert point or is the free tail slot
  assign take    = cmd.store && (greater || at_tail);

  always_comb begin
    entry_nxt = entry_r;
    if (take) begin
      // shift right if the left cell also moves, else land the new value here
      entry_nxt = left_take ? left_entry : cmd.value;
    end else if (cmd.retrieve) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: design/sorted_insert_priority_queue_core.sv
// Top level of the sorted-insert priority queue (min-priority queue).
// Instantiates the spq_cell row; depends on spq_pkg.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-----------------------------------
//  input   | start, busy, in_data       | beat taken when start && !busy
//  result  | out_valid, out_data        | one-cycle strobe, cannot be held
//
// One request beat per cycle; its result appears in the following cycle.
// The row of cells compares every entry against the new value in parallel
// and shifts in the same cycle, which sets the one-beat-per-cycle rate.
// busy stays low; the result side has no stall.
// Reset (rst_n low, synchronous) clears the entry count and the result strobe;
// cell contents are left as they are and only read below the count.
module sorted_insert_priority_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output spq_pkg::out_beat_t out_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_beat_t        out_data_r;
  out_beat_t        out_data_nxt;

  logic      accept;
  logic      full;
  logic      empty;
  logic      do_store;
  logic      do_retrieve;
  cell_cmd_t cmd;

  logic                    take    [DEPTH];
  logic signed [VAL_W-1:0] entries [DEPTH];

  // The row never stalls the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);
  // drop a store into a full row, ignore a retrieve from an empty one
  assign do_store    = accept && (in_data.req_type == REQ_STORE) && !full;
  assign do_retrieve = accept && (in_data.req_type == REQ_RETRIEVE) && !empty;

  assign cmd.store    = do_store;
  assign cmd.retrieve = do_retrieve;
  assign cmd.value    = in_data.value;

  // Cell row: cell 0 holds the smallest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    occupied;
    logic                    at_tail;
    logic                    left_take;
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    assign occupied = (CNT_W'(i) < count_r);
    assign at_tail  = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_take  = take[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied),
      .at_tail     (at_tail),
      .left_take   (left_take),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .take        (take[i]),
      .entry       (entries[i])
    );
  end

  // Advance the count
  always_comb begin
    count_nxt = count_r;
    if (do_store) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_retrieve) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Build the result beat
  always_comb begin
    out_data_nxt.data      = '0;
    out_data_nxt.status    = ST_OK;
    out_data_nxt.occupancy = OCC_W'(count_nxt);
    if (in_data.req_type == REQ_RETRIEVE) begin
      if (empty) begin
        out_data_nxt.status = ST_EMPTY;
      end else begin
        out_data_nxt.data = entries[0];
      end
    end else if (full) begin
      out_data_nxt.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Hold the payload; only meaningful under the strobe
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == REQ_STORE) && full) |=>
      (count_r == $past(count_r)) && (out_data.status == ST_FULL))
    else $error("store into full row changed state");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == REQ_RETRIEVE) && empty) |=>
      (out_data.status == ST_EMPTY) && (out_data.data == '0) && (count_r == '0))
    else $error("retrieve from empty row misreported");
`endif

endmodule
